// ===== sv/kmp_pkg.sv =====
// Shared types and constants of the KMP string matcher.
`default_nettype none

package kmp_pkg;

    localparam int PAT_REG_BYTES = 16;
    localparam int LEN_W         = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD_STEP,
        S_BUILD_WRITE,
        S_SEARCH,
        S_FINISH
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic cfg_wr;
        logic take;
        logic build_adv;
        logic build_link;
        logic build_write;
        logic build_done;
        logic srch_adv;
        logic srch_link;
        logic finish;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic cfg_hit;
        logic build_more;
        logic k_none;
        logic q_none;
        logic eq;
        logic skip;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== sv/kmp_ctrl.sv =====
// Controller state machine of the KMP string matcher.
`default_nettype none

module kmp_ctrl
    import kmp_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    input  wire     i_cfg_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_cfg_ready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    if (i_status.cfg_hit) begin
                        n_state = S_BUILD_STEP;
                    end
                end else if (i_in_valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_BUILD_STEP: begin
                if (!i_status.build_more) begin
                    n_state = S_IDLE;
                end else if (i_status.k_none || i_status.eq) begin
                    n_state = S_BUILD_WRITE;
                end
            end
            S_BUILD_WRITE: begin
                n_state = S_BUILD_STEP;
            end
            S_SEARCH: begin
                if (i_status.skip || i_status.q_none || i_status.eq) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = i_in_valid ? S_SEARCH : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_in_stall  = i_cfg_valid;
                if (i_cfg_valid) begin
                    o_cmd.cfg_wr = 1'b1;
                end else if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                end
            end
            S_BUILD_STEP: begin
                if (!i_status.build_more) begin
                    o_cmd.build_done = 1'b1;
                end else if (i_status.k_none || i_status.eq) begin
                    o_cmd.build_adv = 1'b1;
                end else begin
                    o_cmd.build_link = 1'b1;
                end
            end
            S_BUILD_WRITE: begin
                o_cmd.build_write = 1'b1;
            end
            S_SEARCH: begin
                if (!i_status.skip) begin
                    if (i_status.q_none || i_status.eq) begin
                        o_cmd.srch_adv = 1'b1;
                    end else begin
                        o_cmd.srch_link = 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    o_in_stall   = 1'b0;
                    o_cmd.take   = i_in_valid;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // At most one datapath action per cycle (the byte latch may ride along).
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.cfg_wr, o_cmd.build_adv, o_cmd.build_link, o_cmd.build_write,
                  o_cmd.build_done, o_cmd.srch_adv, o_cmd.srch_link, o_cmd.finish}))
        else $error("kmp_ctrl: more than one datapath action");

    // A result is only written when the output register can take it.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_status.out_free)
        else $error("kmp_ctrl: finish while output register blocked");

    // A table rebuild always returns to idle through a build step.
    a_build_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUILD_WRITE) |=> (r_state == S_BUILD_STEP))
        else $error("kmp_ctrl: build write not followed by build step");

endmodule

`default_nettype wire

// ===== sv/kmp_dp.sv =====
// Datapath of the KMP string matcher: pattern registers, nextval table, search state.
`default_nettype none

module kmp_dp
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire [7:0]             i_text_byte,
    input  wire                   i_last_byte,
    input  wire                   i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_match_here,
    output logic                  o_found,
    output logic [LEN_W-1:0]      o_matched_count,
    output logic                  o_text_end
);

    localparam int CAP = (MAX_PATTERN < PAT_REG_BYTES) ? MAX_PATTERN : PAT_REG_BYTES;
    localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int PW  = $clog2(CAP + 1);

    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [LEN_W-1:0]      r_len;
    logic [PW-1:0]         r_q;
    logic                  r_q_none;
    logic [IW-1:0]         r_k;
    logic                  r_k_none;
    logic                  r_found;
    logic                  r_out_valid;
    logic [7:0]            r_byte;
    logic                  r_last;
    logic                  r_match_here;
    logic                  r_found_out;
    logic [LEN_W-1:0]      r_count;
    logic                  r_text_end;
    logic                  r_fail_none [CAP];
    logic [IW-1:0]         r_fail_idx  [CAP];

    logic [2*CFG_DATA_W-1:0] pat_vec;
    logic [PW-1:0]           eff_len;
    logic [IW-1:0]           q_idx;
    logic [IW-1:0]           rd_idx;
    logic                    rd_none;
    logic [IW-1:0]           rd_val;
    logic [7:0]              cmp_a;
    logic [7:0]              cmp_b;
    logic                    eq;
    logic                    cfg_hit;
    logic                    fin_hit;
    logic [PW-1:0]           fin_q;
    logic                    fin_found;

    assign pat_vec = {r_pat_hi, r_pat_lo};
    assign eff_len = (r_len > LEN_W'(CAP)) ? PW'(CAP) : r_len[PW-1:0];
    assign q_idx   = r_q[IW-1:0];

    // Single table read port: k while building, q while searching.
    assign rd_idx  = r_k_none ? q_idx : r_k;
    assign rd_none = (rd_idx == '0) || r_fail_none[rd_idx];
    assign rd_val  = r_fail_idx[rd_idx];

    // Shared comparator: pat[q] against pat[k] (build) or the text byte (search).
    assign cmp_a = pat_vec[8*q_idx +: 8];
    assign cmp_b = r_k_none ? r_byte : pat_vec[8*r_k +: 8];
    assign eq    = (cmp_a == cmp_b);

    assign cfg_hit = (i_cfg_index == REG_PAT_LO) || (i_cfg_index == REG_PAT_HI)
                  || (i_cfg_index == REG_PAT_LEN);

    // Result of the current byte.
    always_comb begin
        fin_hit   = !r_found && ((eff_len == '0) || (r_q >= eff_len));
        fin_found = r_found || fin_hit;
        fin_q     = fin_hit ? eff_len : r_q;
    end

    always_comb begin
        o_status.cfg_hit    = cfg_hit;
        o_status.build_more = ((PW+1)'(r_q) + (PW+1)'(1)) < (PW+1)'(eff_len);
        o_status.k_none     = r_k_none;
        o_status.q_none     = r_q_none;
        o_status.eq         = eq;
        o_status.skip       = r_found || (eff_len == '0);
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo    <= '0;
            r_pat_hi    <= '0;
            r_len       <= '0;
            r_q         <= '0;
            r_q_none    <= 1'b0;
            r_k         <= '0;
            r_k_none    <= 1'b1;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_wr) begin
                case (i_cfg_index)
                    REG_PAT_LO:  r_pat_lo <= i_cfg_data;
                    REG_PAT_HI:  r_pat_hi <= i_cfg_data;
                    REG_PAT_LEN: r_len    <= i_cfg_data[LEN_W-1:0];
                    default:     r_len    <= r_len;
                endcase
                if (cfg_hit) begin
                    r_q      <= '0;
                    r_q_none <= 1'b0;
                    r_k_none <= 1'b1;
                    r_found  <= 1'b0;
                end
            end
            if (i_cmd.build_adv) begin
                r_q      <= r_q + PW'(1);
                r_k      <= r_k_none ? '0 : r_k + IW'(1);
                r_k_none <= 1'b0;
            end
            if (i_cmd.build_link) begin
                r_k      <= rd_val;
                r_k_none <= rd_none;
            end
            if (i_cmd.build_done) begin
                r_q      <= '0;
                r_q_none <= 1'b0;
                r_k_none <= 1'b1;
            end
            if (i_cmd.srch_adv) begin
                r_q      <= r_q_none ? '0 : r_q + PW'(1);
                r_q_none <= 1'b0;
            end
            if (i_cmd.srch_link) begin
                r_q      <= PW'(rd_val);
                r_q_none <= rd_none;
            end
            if (i_cmd.finish) begin
                r_q     <= r_last ? '0 : fin_q;
                r_found <= r_last ? 1'b0 : fin_found;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.build_write) begin
            r_fail_none[q_idx] <= eq ? rd_none : 1'b0;
            r_fail_idx[q_idx]  <= eq ? rd_val : r_k;
        end
        if (i_cmd.take) begin
            r_byte <= i_text_byte;
            r_last <= i_last_byte;
        end
        if (i_cmd.finish) begin
            r_match_here <= fin_hit;
            r_found_out  <= fin_found;
            r_count      <= LEN_W'(fin_q);
            r_text_end   <= r_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_match_here    = r_match_here;
    assign o_found         = r_found_out;
    assign o_matched_count = r_count;
    assign o_text_end      = r_text_end;

    // Once found, progress sits at the pattern length until the text ends.
    a_found_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_q == eff_len))
        else $error("kmp_dp: found flag without full progress");

    // The build prefix index always trails the build position.
    a_k_below_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_k_none |-> (PW'(r_k) < r_q))
        else $error("kmp_dp: build prefix index not below position");

    // A reported hit always carries the found flag.
    a_hit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_match_here) |-> r_found_out)
        else $error("kmp_dp: match reported without found");

endmodule

`default_nettype wire

// ===== sv/kmp_string_matcher.sv =====
// Top level of the streaming KMP string matcher.
// A taken text byte waits in the byte latch while the search state follows failure links;
//   the finish state then writes its result once the output register is free. A new byte is
//   taken in idle or as a result is written, so bytes are handled one at a time over the
//   shared pattern comparator and table read port.
// A write to a pattern or length register rebuilds the nextval table.
// Reset: synchronous, active low; pattern registers and length clear, search state clears,
//   no rebuild is needed, and the block is ready as soon as reset drops.
`default_nettype none

module kmp_string_matcher
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // text byte requests
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire [7:0]             i_text_byte,
    input  wire                   i_last_byte,
    // result requests
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic                  o_match_here,
    output logic                  o_found,
    output logic [LEN_W-1:0]      o_matched_count,
    output logic                  o_text_end,
    // register writes
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // Controller: sequences table build, failure-link walk and result hand-off.
    kmp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    // Datapath: pattern, nextval table, match progress and the output register.
    kmp_dp #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_text_byte     (i_text_byte),
        .i_last_byte     (i_last_byte),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_match_here    (o_match_here),
        .o_found         (o_found),
        .o_matched_count (o_matched_count),
        .o_text_end      (o_text_end)
    );

endmodule

`default_nettype wire
